### design/mi3_pkg.sv
// Shared widths, types and constants for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  // Field widths.
  localparam int IN_W   = 16;
  localparam int OUT_W  = 32;

  // Exact integer widths of the adjugate and determinant arithmetic.
  localparam int PROD_W  = 2 * IN_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int DETP_W  = CROSS_W + IN_W;
  localparam int DET_W   = DETP_W + 2;

  // The quotient is scaled by 2^28 to land in Q16.16.
  localparam int FRAC_SH = 28;
  localparam int NUM_W   = CROSS_W + FRAC_SH;

  // Quotient bits developed by the divider (one beyond the 32-bit result),
  // plus one overflow step above them.
  localparam int QB   = OUT_W + 1;
  localparam int NST  = QB + 1;
  localparam int EW   = DET_W + QB + 1;

  // Pipeline stages: five adjugate stages, divider steps, output register.
  localparam int ADJ_LAT = 5;
  localparam int LAT     = ADJ_LAT + NST + 1;

  // Sideband that travels with every element through the divider.
  typedef struct packed {
    logic valid;
    logic neg;
    logic sing;
  } mi3_side_t;

endpackage

### design/mi3_adj.sv
// Adjugate and determinant pipeline: five register stages.
`timescale 1ns / 1ps
module mi3_adj (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  input  logic signed [mi3_pkg::IN_W-1:0]       m_i [9],
  output logic                                  valid_o,
  output logic                                  sing_o,
  output logic [mi3_pkg::NUM_W-1:0]             num_o [9],
  output logic [mi3_pkg::DET_W-1:0]             den_o,
  output logic                                  neg_o [9]
);
  import mi3_pkg::*;

  // Columns, indexed [column][row].
  logic signed [IN_W-1:0]    col [3][3];
  logic signed [PROD_W-1:0]  pa_nxt [3][3], pb_nxt [3][3];
  logic signed [PROD_W-1:0]  pa_r [3][3], pb_r [3][3];
  logic signed [IN_W-1:0]    cc1_r [3], cc2_r [3];
  logic signed [CROSS_W-1:0] cr_nxt [3][3];
  logic signed [CROSS_W-1:0] cr2_r [3][3], cr3_r [3][3], cr4_r [3][3];
  logic signed [DETP_W-1:0]  dp_nxt [3], dp_r [3];
  logic signed [DET_W-1:0]   det_nxt, det_r;
  logic [4:0]                vld_r;
  logic [NUM_W-1:0]          num_nxt [9];
  logic                      neg_nxt [9];
  logic [DET_W-1:0]          den_nxt;
  logic [NUM_W-1:0]          num_r [9];
  logic                      neg_r [9];
  logic [DET_W-1:0]          den_r;
  logic                      sing_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        col[c][r] = m_i[r * 3 + c];
      end
    end
  end

  // Stage 1: the eighteen partial products of the three cross products.
  // Row p is column (p+1) crossed with column (p+2).
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 3; j++) begin
        pa_nxt[p][j] = PROD_W'(col[(p+1)%3][(j+1)%3]) * PROD_W'(col[(p+2)%3][(j+2)%3]);
        pb_nxt[p][j] = PROD_W'(col[(p+1)%3][(j+2)%3]) * PROD_W'(col[(p+2)%3][(j+1)%3]);
      end
    end
  end

  // Stage 2: cross-product components.
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 3; j++) begin
        cr_nxt[p][j] = CROSS_W'(pa_r[p][j]) - CROSS_W'(pb_r[p][j]);
      end
    end
  end

  // Stage 3 and 4: determinant as (a x b) . c.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dp_nxt[j] = DETP_W'(cr2_r[2][j]) * DETP_W'(cc2_r[j]);
    end
    det_nxt = DET_W'(dp_r[0]) + DET_W'(dp_r[1]) + DET_W'(dp_r[2]);
  end

  // Stage 5: magnitudes and signs for the dividers.
  always_comb begin
    logic [CROSS_W-1:0] rmag;
    den_nxt = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    for (int k = 0; k < 9; k++) begin
      rmag = cr4_r[k/3][k%3][CROSS_W-1] ? CROSS_W'(-cr4_r[k/3][k%3])
                                         : CROSS_W'(cr4_r[k/3][k%3]);
      num_nxt[k] = {rmag, {FRAC_SH{1'b0}}};
      neg_nxt[k] = cr4_r[k/3][k%3][CROSS_W-1] ^ det_r[DET_W-1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    cc1_r   <= col[2];
    cc2_r   <= cc1_r;
    cr2_r   <= cr_nxt;
    cr3_r   <= cr2_r;
    cr4_r   <= cr3_r;
    dp_r    <= dp_nxt;
    det_r   <= det_nxt;
    num_r   <= num_nxt;
    neg_r   <= neg_nxt;
    den_r   <= den_nxt;
    sing_r  <= (det_r == '0);
  end

  assign valid_o = vld_r[4];
  assign sing_o  = sing_r;
  assign num_o   = num_r;
  assign neg_o   = neg_r;
  assign den_o   = den_r;

endmodule

### design/mi3_div.sv
// Restoring divider, one quotient bit per stage, with Q16.16 saturation.
`timescale 1ns / 1ps
module mi3_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mi3_pkg::mi3_side_t             side_i,
  input  logic [mi3_pkg::NUM_W-1:0]      num_i,
  input  logic [mi3_pkg::DET_W-1:0]      den_i,
  output mi3_pkg::mi3_side_t             side_o,
  output logic signed [mi3_pkg::OUT_W-1:0] q_o,
  output logic                           sat_o
);
  import mi3_pkg::*;

  logic [NUM_W-1:0] rem_r  [1:NST];
  logic [QB-1:0]    q_r    [1:NST];
  logic             ovf_r  [1:NST];
  logic [DET_W-1:0] den_r  [1:NST];
  mi3_side_t        side_r [1:NST];

  logic signed [OUT_W-1:0] q_nxt, qo_r;
  logic                    sat_nxt, sat_r;
  mi3_side_t               so_r;

  for (genvar i = 1; i <= NST; i++) begin : g_step
    // The first step only checks for a quotient of 2^33 or more.
    localparam int K = NST - i;
    logic [NUM_W-1:0] rem_in;
    logic [QB-1:0]    q_in;
    logic             ovf_in;
    logic [DET_W-1:0] den_in;
    mi3_side_t        side_in;
    logic [EW-1:0]    rem_ext, dsh;
    logic             ge;

    if (i == 1) begin : g_first
      assign rem_in  = num_i;
      assign q_in    = '0;
      assign ovf_in  = 1'b0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign q_in    = q_r[i-1];
      assign ovf_in  = ovf_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign rem_ext = EW'(rem_in);
    assign dsh     = EW'(den_in) << K;
    assign ge      = (rem_ext >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i].valid <= side_in.valid;
      end
    end

    // Trial subtract; the overflow step keeps the remainder.
    always_ff @(posedge clk) begin
      side_r[i].neg  <= side_in.neg;
      side_r[i].sing <= side_in.sing;
      den_r[i]       <= den_in;
      if (K == QB) begin
        rem_r[i] <= rem_in;
        q_r[i]   <= q_in;
        ovf_r[i] <= ge;
      end else begin
        rem_r[i] <= ge ? NUM_W'(rem_ext - dsh) : rem_in;
        q_r[i]   <= q_in | (ge ? (QB'(1) << K) : '0);
        ovf_r[i] <= ovf_in;
      end
    end
  end

  // Sign, clamp to the Q16.16 range, and zero on a singular matrix.
  always_comb begin
    logic [QB-1:0] qm;
    logic          big_pos, big_neg;
    qm      = q_r[NST];
    big_pos = ovf_r[NST] || (qm > QB'({1'b0, {(OUT_W-1){1'b1}}}));
    big_neg = ovf_r[NST] || (qm > QB'({1'b1, {(OUT_W-1){1'b0}}}));
    if (side_r[NST].sing) begin
      q_nxt   = '0;
      sat_nxt = 1'b0;
    end else if (side_r[NST].neg) begin
      q_nxt   = big_neg ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-qm);
      sat_nxt = big_neg;
    end else begin
      q_nxt   = big_pos ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(qm);
      sat_nxt = big_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r.valid <= 1'b0;
    end else begin
      so_r.valid <= side_r[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    so_r.neg  <= side_r[NST].neg;
    so_r.sing <= side_r[NST].sing;
    qo_r      <= q_nxt;
    sat_r     <= sat_nxt;
  end

  assign side_o = so_r;
  assign q_o    = qo_r;
  assign sat_o  = sat_r;

endmodule

### design/mat3_inverse.sv
// Top level of the pipelined 3x3 matrix inverse.
// Usage:
//   Drive the nine Q4.12 entries on in_r*_c* and pulse start. An item is
//   taken at every clock edge where start is high and busy is low; busy
//   stays low, so a new matrix can enter on every cycle.
//   Each result appears for one cycle with out_valid high: nine Q16.16
//   entries of the inverse, out_singular when the determinant is zero (all
//   entries then zero) and out_saturated when an entry was clamped.
//   Five stages build the adjugate and determinant, 34 stages of a
//   restoring divider develop one quotient bit each (the first catches
//   quotients too large for any result), and one register applies sign
//   and clamp. Throughput is one matrix per cycle, set by the nine
//   parallel divider pipelines.
//   The receiver cannot stall: every result must be taken when shown.
//   A synchronous reset clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps
module mat3_inverse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_r0_c0,
  input  logic signed [15:0] in_r0_c1,
  input  logic signed [15:0] in_r0_c2,
  input  logic signed [15:0] in_r1_c0,
  input  logic signed [15:0] in_r1_c1,
  input  logic signed [15:0] in_r1_c2,
  input  logic signed [15:0] in_r2_c0,
  input  logic signed [15:0] in_r2_c1,
  input  logic signed [15:0] in_r2_c2,
  output logic               out_valid,
  output logic signed [31:0] out_r0_c0,
  output logic signed [31:0] out_r0_c1,
  output logic signed [31:0] out_r0_c2,
  output logic signed [31:0] out_r1_c0,
  output logic signed [31:0] out_r1_c1,
  output logic signed [31:0] out_r1_c2,
  output logic signed [31:0] out_r2_c0,
  output logic signed [31:0] out_r2_c1,
  output logic signed [31:0] out_r2_c2,
  output logic               out_singular,
  output logic               out_saturated
);
  import mi3_pkg::*;

  logic signed [IN_W-1:0]  m [9];
  logic                    adj_valid, adj_sing;
  logic [NUM_W-1:0]        adj_num [9];
  logic [DET_W-1:0]        adj_den;
  logic                    adj_neg [9];
  mi3_side_t               div_side_in [9];
  mi3_side_t               div_side_out [9];
  logic signed [OUT_W-1:0] q [9];
  logic [8:0]              sat;

  // The pipeline never holds off a new item.
  assign busy = 1'b0;

  assign m[0] = in_r0_c0;
  assign m[1] = in_r0_c1;
  assign m[2] = in_r0_c2;
  assign m[3] = in_r1_c0;
  assign m[4] = in_r1_c1;
  assign m[5] = in_r1_c2;
  assign m[6] = in_r2_c0;
  assign m[7] = in_r2_c1;
  assign m[8] = in_r2_c2;

  mi3_adj u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start & ~busy),
    .m_i     (m),
    .valid_o (adj_valid),
    .sing_o  (adj_sing),
    .num_o   (adj_num),
    .den_o   (adj_den),
    .neg_o   (adj_neg)
  );

  // One divider pipeline per output entry.
  for (genvar k = 0; k < 9; k++) begin : g_div
    assign div_side_in[k] = '{valid: adj_valid, neg: adj_neg[k], sing: adj_sing};

    mi3_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (div_side_in[k]),
      .num_i  (adj_num[k]),
      .den_i  (adj_den),
      .side_o (div_side_out[k]),
      .q_o    (q[k]),
      .sat_o  (sat[k])
    );
  end

  assign out_valid     = div_side_out[0].valid;
  assign out_singular  = div_side_out[0].sing;
  assign out_saturated = |sat;
  assign out_r0_c0 = q[0];
  assign out_r0_c1 = q[1];
  assign out_r0_c2 = q[2];
  assign out_r1_c0 = q[3];
  assign out_r1_c1 = q[4];
  assign out_r1_c2 = q[5];
  assign out_r2_c0 = q[6];
  assign out_r2_c1 = q[7];
  assign out_r2_c2 = q[8];

`ifndef SYNTHESIS
  // A result only follows an item taken exactly one latency earlier.
  a_valid_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching item");

  // A singular result has a zero diagonal and is never saturated.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (!out_saturated && out_r0_c0 == '0 &&
      out_r1_c1 == '0 && out_r2_c2 == '0))
    else $error("singular result not cleared");

  // Saturation shows up as at least one clamped entry.
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (q[0] == 32'sh7fffffff || q[0] == 32'sh80000000 ||
       q[1] == 32'sh7fffffff || q[1] == 32'sh80000000 ||
       q[2] == 32'sh7fffffff || q[2] == 32'sh80000000 ||
       q[3] == 32'sh7fffffff || q[3] == 32'sh80000000 ||
       q[4] == 32'sh7fffffff || q[4] == 32'sh80000000 ||
       q[5] == 32'sh7fffffff || q[5] == 32'sh80000000 ||
       q[6] == 32'sh7fffffff || q[6] == 32'sh80000000 ||
       q[7] == 32'sh7fffffff || q[7] == 32'sh80000000 ||
       q[8] == 32'sh7fffffff || q[8] == 32'sh80000000))
    else $error("saturation flag without a clamped entry");
`endif

endmodule

### tb/tb_mat3_inverse.sv
// Self-checking testbench for the pipelined 3x3 matrix inverse.
`timescale 1ns / 1ps
module tb_mat3_inverse;
  import mi3_pkg::*;

  typedef logic signed [IN_W-1:0] entry_t;
  typedef struct {
    logic signed [OUT_W-1:0] inv [9];
    logic                    sing;
    logic                    sat;
  } inverse_t;

  // Holds predicted inverses in order and checks the block's results.
  class inverse_board;
    inverse_t pending[$];
    int       errors;

    function void note_matrix(entry_t m [9]);
      longint ca[3], cb[3], cc[3], adj[3][3], det, q;
      inverse_t r;
      for (int i = 0; i < 3; i++) begin
        ca[i] = m[i*3];
        cb[i] = m[i*3+1];
        cc[i] = m[i*3+2];
      end
      adj[0][0] = cb[1]*cc[2] - cb[2]*cc[1];
      adj[0][1] = cb[2]*cc[0] - cb[0]*cc[2];
      adj[0][2] = cb[0]*cc[1] - cb[1]*cc[0];
      adj[1][0] = cc[1]*ca[2] - cc[2]*ca[1];
      adj[1][1] = cc[2]*ca[0] - cc[0]*ca[2];
      adj[1][2] = cc[0]*ca[1] - cc[1]*ca[0];
      adj[2][0] = ca[1]*cb[2] - ca[2]*cb[1];
      adj[2][1] = ca[2]*cb[0] - ca[0]*cb[2];
      adj[2][2] = ca[0]*cb[1] - ca[1]*cb[0];
      det = adj[2][0]*cc[0] + adj[2][1]*cc[1] + adj[2][2]*cc[2];
      r.sing = (det == 0);
      r.sat  = 1'b0;
      for (int k = 0; k < 9; k++) begin
        if (det == 0) begin
          r.inv[k] = '0;
        end else begin
          // The numerator fits 62 bits; SV division truncates toward zero.
          q = (adj[k/3][k%3] * (longint'(1) << FRAC_SH)) / det;
          if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            r.sat = 1'b1;
          end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            r.sat = 1'b1;
          end
          r.inv[k] = q[OUT_W-1:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(inverse_t got);
      inverse_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with no matrix outstanding", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got.inv[k] !== e.inv[k]) begin
          $display("%0t: entry r%0d c%0d expected %0d actual %0d", $time, k/3, k%3,
                   e.inv[k], got.inv[k]);
          errors++;
        end
      end
      if (got.sing !== e.sing) begin
        $display("%0t: singular expected %0b actual %0b", $time, e.sing, got.sing);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0, busy;
  entry_t mat [9] = '{default: '0};
  logic out_valid, out_singular, out_saturated;
  logic signed [31:0] o00, o01, o02, o10, o11, o12, o20, o21, o22;
  inverse_board board = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mat3_inverse i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r0_c0(mat[0]), .in_r0_c1(mat[1]), .in_r0_c2(mat[2]),
    .in_r1_c0(mat[3]), .in_r1_c1(mat[4]), .in_r1_c2(mat[5]),
    .in_r2_c0(mat[6]), .in_r2_c1(mat[7]), .in_r2_c2(mat[8]),
    .out_valid(out_valid),
    .out_r0_c0(o00), .out_r0_c1(o01), .out_r0_c2(o02),
    .out_r1_c0(o10), .out_r1_c1(o11), .out_r1_c2(o12),
    .out_r2_c0(o20), .out_r2_c1(o21), .out_r2_c2(o22),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  // Accepted items on both sides, sampled at the rising edge.
  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && out_valid) begin
      got.inv = '{o00, o01, o02, o10, o11, o12, o20, o21, o22};
      got.sing = out_singular;
      got.sat  = out_saturated;
      board.check_result(got);
    end
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one matrix, idling first at the current rate, until accepted.
  task automatic send_matrix(entry_t m [9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    for (int k = 0; k < 9; k++) mat[k] <= m[k];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_matrix(m);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Random matrix: as often diagonally dominant as raw bits, sometimes tiny.
  function automatic void rand_matrix(output entry_t m [9]);
    int kind = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 4) m[k] = entry_t'(int'($urandom_range(8191)) - 4096);
      else if (kind < 6) m[k] = entry_t'(int'($urandom_range(15)) - 8);
      else m[k] = entry_t'($urandom);
    end
    if (kind < 4) begin
      m[0] = m[0] + 16'sd20000;
      m[4] = m[4] - 16'sd20000;
      m[8] = m[8] + 16'sd20000;
    end
    // Sometimes copy a column to force a zero determinant.
    if ($urandom_range(19) == 0) begin
      m[2] = m[0];
      m[5] = m[3];
      m[8] = m[6];
    end
  endfunction

  initial begin
    entry_t m [9];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero, extremes, singular, tiny and scaled cases.
    m = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096};           send_matrix(m);
    m = '{default: 0};                                    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                     send_matrix(m);
    m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};                  send_matrix(m);
    m = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};         send_matrix(m);
    m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};      send_matrix(m);
    m = '{-32768, 32767, -32768, 32767, -32768, 32767, 1, 2, 3}; send_matrix(m);
    m = '{default: -32768};                               send_matrix(m);
    m = '{default: 32767};                                send_matrix(m);
    m = '{1, 2, 3, 4, 5, 6, 7, 8, 9};                     send_matrix(m);
    m = '{0, 4096, 0, 4096, 0, 0, 0, 0, 4096};            send_matrix(m);
    m = '{8192, 4096, 0, 4096, 8192, 4096, 0, 4096, 8192}; send_matrix(m);
    m = '{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 1};   send_matrix(m);
    m = '{1, 1, 0, 1, -1, 0, 0, 0, 1};                    send_matrix(m);
    m = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768}; send_matrix(m);
    // Pause until every outstanding inverse has returned.
    drain();

    // Random phases with sender idle rates of 0, 51, 0 and 7 percent.
    foreach (m[k]) m[k] = '0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 3) ? 7 : 0;
      repeat (335) begin
        rand_matrix(m);
        send_matrix(m);
      end
    end
    drain();
    repeat (LAT + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### mat3_inverse.f
design/mi3_pkg.sv
design/mi3_adj.sv
design/mi3_div.sv
design/mat3_inverse.sv
tb/tb_mat3_inverse.sv
